### rtl/assert_macros.svh
// Assertion macros shared by the unpacker RTL.
// Clock and reset names are those used throughout the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define FCU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define FCU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/fcu_pkg.sv
// ----------------------------------------------------------------------------
// fcu_pkg
// Types and constants shared by the fixed-length code unpacker.
// ----------------------------------------------------------------------------
package fcu_pkg;

  localparam int unsigned SymW   = 7;   // symbol width
  localparam int unsigned WidthW = 4;   // code width field
  localparam int unsigned CountW = 7;   // entry count field
  localparam int unsigned BufW   = 15;  // longest code held
  localparam int unsigned HeldW  = 4;

  localparam logic [HeldW-1:0] HdrBits = 4'd11;
  localparam logic [HeldW-1:0] SymBits = 4'd7;
  localparam logic [WidthW-1:0] MaxTableWidth = 4'd7;

  // Parser to table requests, one cycle each
  typedef struct packed {
    logic            clr;       // drop all valid marks
    logic            wr_en;
    logic [SymW-1:0] wr_code;
    logic [SymW-1:0] wr_sym;
    logic            rd_en;     // a data code is complete
    logic            rd_wide;   // code wider than a table index
    logic [SymW-1:0] rd_code;
    logic            rd_last;   // last code this group can complete
  } tbl_req_t;

endpackage

### rtl/fcu_parser.sv
// ----------------------------------------------------------------------------
// fcu_parser
// Bit-serial stream parser: header, table entries, then data codes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcu_parser #(
  parameter int unsigned GROUP_BITS = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [GROUP_BITS-1:0] group_bits_i,
  input  logic                  first_group_i,
  input  logic                  out_free_i,
  output fcu_pkg::tbl_req_t     req_o
);
  import fcu_pkg::*;

  localparam int unsigned CntW = $clog2(GROUP_BITS + 1);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SYMBOL = 2'd1;
  localparam logic [1:0] PH_CODE   = 2'd2;
  localparam logic [1:0] PH_DATA   = 2'd3;

  logic [GROUP_BITS-1:0] grp_q, grp_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [BufW-1:0]       buf_q, buf_d;
  logic [HeldW-1:0]      held_q, held_d;
  logic [1:0]            phase_q, phase_d;
  logic [WidthW-1:0]     width_q, width_d;
  logic [CountW-1:0]     entries_q, entries_d;
  logic [SymW-1:0]       pend_q, pend_d;

  logic [BufW-1:0]   buf_n;
  logic [HeldW-1:0]  held_n;
  logic [BufW-1:0]   code;
  logic [CntW-1:0]   rem;
  logic [CountW-1:0] entries_m1;
  logic              needs_out;
  logic              do_step;
  logic              accept;

  always_comb begin
    buf_n      = {buf_q[BufW-2:0], grp_q[GROUP_BITS-1]};
    held_n     = held_q + 4'd1;
    code       = buf_n & ~({BufW{1'b1}} << width_q);
    rem        = cnt_q - CntW'(1);
    entries_m1 = entries_q - 7'd1;
    needs_out  = (phase_q == PH_DATA) && (width_q != '0) && (held_n >= width_q);
    do_step    = (cnt_q != '0) && (!needs_out || out_free_i);
    in_stall_o = (cnt_q > CntW'(1)) || ((cnt_q == CntW'(1)) && !do_step);
    accept     = in_valid_i && !in_stall_o;

    grp_d     = grp_q;
    cnt_d     = cnt_q;
    buf_d     = buf_q;
    held_d    = held_q;
    phase_d   = phase_q;
    width_d   = width_q;
    entries_d = entries_q;
    pend_d    = pend_q;
    req_o     = '0;

    if (do_step) begin
      grp_d  = grp_q << 1;
      cnt_d  = rem;
      buf_d  = buf_n;
      held_d = held_n;
      unique case (phase_q)
        PH_HEADER: begin
          if (held_n >= HdrBits) begin
            width_d   = buf_n[10:7];
            entries_d = buf_n[6:0];
            phase_d   = (buf_n[6:0] != '0) ? PH_SYMBOL : PH_DATA;
            buf_d     = '0;
            held_d    = '0;
          end
        end
        PH_SYMBOL: begin
          if (held_n >= SymBits) begin
            pend_d  = buf_n[6:0];
            buf_d   = '0;
            held_d  = '0;
            phase_d = PH_CODE;
            if (width_q == '0) begin
              // zero width: entry takes only its symbol and loads entry 0
              req_o.wr_en   = 1'b1;
              req_o.wr_code = '0;
              req_o.wr_sym  = buf_n[6:0];
              entries_d     = entries_m1;
              phase_d       = (entries_m1 != '0) ? PH_SYMBOL : PH_DATA;
            end
          end
        end
        PH_CODE: begin
          if (held_n >= width_q) begin
            req_o.wr_en   = (width_q <= MaxTableWidth);
            req_o.wr_code = code[6:0];
            req_o.wr_sym  = pend_q;
            entries_d     = entries_m1;
            phase_d       = (entries_m1 != '0) ? PH_SYMBOL : PH_DATA;
            buf_d         = '0;
            held_d        = '0;
          end
        end
        default: begin
          if (width_q == '0) begin
            buf_d  = '0;
            held_d = '0;
          end else if (held_n >= width_q) begin
            req_o.rd_en   = 1'b1;
            req_o.rd_wide = (width_q > MaxTableWidth);
            req_o.rd_code = code[6:0];
            // no later code fits in what is left of the group
            req_o.rd_last = (WidthW + CntW)'(rem) < (WidthW + CntW)'(width_q);
            buf_d         = '0;
            held_d        = '0;
          end
        end
      endcase
    end

    if (accept) begin
      grp_d = group_bits_i;
      cnt_d = CntW'(GROUP_BITS);
      if (first_group_i) begin
        req_o.clr = 1'b1;
        buf_d     = '0;
        held_d    = '0;
        phase_d   = PH_HEADER;
        width_d   = '0;
        entries_d = '0;
        pend_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      buf_q     <= '0;
      held_q    <= '0;
      phase_q   <= PH_HEADER;
      width_q   <= '0;
      entries_q <= '0;
      pend_q    <= '0;
    end else begin
      cnt_q     <= cnt_d;
      buf_q     <= buf_d;
      held_q    <= held_d;
      phase_q   <= phase_d;
      width_q   <= width_d;
      entries_q <= entries_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  `FCU_ASSERT(a_no_rd_wr_mix, !(req_o.rd_en && req_o.wr_en), "table read and write together")
  `FCU_ASSERT(a_idle_takes, (cnt_q == '0) |-> !in_stall_o, "stalled with no bits left")
  `FCU_ASSERT(a_restart, req_o.clr |=> (phase_q == PH_HEADER && held_q == '0), "restart missed")

endmodule

### rtl/fcu_lookup.sv
// ----------------------------------------------------------------------------
// fcu_lookup
// Code-to-symbol table memory, valid marks and the output word register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcu_lookup #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fcu_pkg::tbl_req_t req_i,
  output logic              out_free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [6:0]        symbol_o,
  output logic              code_known_o,
  output logic              last_of_group_o
);
  import fcu_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [SymW-1:0]        tbl_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [SymW-1:0]        rdata_q;
  logic                   out_valid_q;
  logic                   known_q;
  logic                   last_q;

  logic          wr_hit;
  logic          rd_in_range;
  logic          rd_known;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign wr_addr     = req_i.wr_code[AW-1:0];
  assign rd_addr     = req_i.rd_code[AW-1:0];
  assign wr_hit      = req_i.wr_en && ({1'b0, req_i.wr_code} < 8'(TABLE_DEPTH));
  assign rd_in_range = {1'b0, req_i.rd_code} < 8'(TABLE_DEPTH);
  assign rd_known    = req_i.rd_en && !req_i.rd_wide && rd_in_range && valid_q[rd_addr];

  // Read data register doubles as the output symbol; it only moves on a read.
  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      tbl_mem[wr_addr] <= req_i.wr_sym;
    end
    if (rd_known) begin
      rdata_q <= tbl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clr) begin
      valid_q <= '0;
    end else if (wr_hit) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_i.rd_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      known_q <= rd_known;
      last_q  <= req_i.rd_last;
    end
  end

  assign out_free_o      = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign code_known_o    = known_q;
  assign last_of_group_o = last_q;
  assign symbol_o        = known_q ? rdata_q : '0;

  `FCU_ASSERT(a_no_overwrite, !(req_i.rd_en && out_valid_q && out_stall_i), "word overwritten")
  `FCU_ASSERT(a_rd_lands, req_i.rd_en |=> out_valid_o, "lookup result lost")
  `FCU_ASSERT(a_unknown_zero, (out_valid_o && !code_known_o) |-> (symbol_o == '0), "bad symbol")

endmodule

### rtl/fixed_length_code_unpacker_core.sv
// ----------------------------------------------------------------------------
// fixed_length_code_unpacker_core
// Parses a header and a code table from a packed bit stream, then decodes
// each later fixed-length code to its symbol.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid_i/in_stall_o | group_bits_i, first_group_i
//  out     | output    | out_valid_o/out_stall_i | symbol_o, code_known_o,
//          |           |                       | last_of_group_o
//
//  One stream bit is parsed per cycle unless a completed code waits on a stalled
//  output, and the next group is taken in the cycle its last bit is parsed.
//  A decoded code reads the table memory and appears in the output register
//  the cycle after its last bit.
//  A stalled output holds the bit that completes the next code.
//  Reset clears the parser and all valid marks; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fixed_length_code_unpacker_core #(
  parameter int unsigned TABLE_DEPTH = 128,
  parameter int unsigned GROUP_BITS  = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [GROUP_BITS-1:0] group_bits_i,
  input  logic                  first_group_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [6:0]            symbol_o,
  output logic                  code_known_o,
  output logic                  last_of_group_o
);
  import fcu_pkg::*;

  tbl_req_t req;
  logic     out_free;

  fcu_parser #(
    .GROUP_BITS(GROUP_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .group_bits_i (group_bits_i),
    .first_group_i(first_group_i),
    .out_free_i   (out_free),
    .req_o        (req)
  );

  fcu_lookup #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_lookup (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .out_free_o     (out_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .symbol_o       (symbol_o),
    .code_known_o   (code_known_o),
    .last_of_group_o(last_of_group_o)
  );

endmodule
